>>> hdl/ptls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptls_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned NUM_CHAN    = 3;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  LUMA_KR   = 8'd77;
   localparam logic [7:0]  LUMA_KG   = 8'd150;
   localparam logic [7:0]  LUMA_KB   = 8'd29;
   localparam logic [7:0]  CHAN_MAX  = 8'd255;
   localparam logic [9:0]  SAT_RESET = 10'd332;

   typedef enum logic {
      OP_TABLE = 1'b0,
      OP_PIXEL = 1'b1
   } op_kind_type;

   // Classified work item. Table write: idx[0] = entry, idx[1] = value.
   // Pixel: idx[0..2] = red, green, blue.
   typedef struct packed {
      op_kind_type                    kind;
      logic [NUM_CHAN-1:0][7:0]       idx;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic pop;
      logic s3_valid;
   } back_stat_type;

endpackage

`default_nettype wire

>>> hdl/ptls_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ptls_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] table_index;
   logic [7:0] table_value;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, command, table_index, table_value,
                   red_in, green_in, blue_in, input ready);
   modport sink   (input valid, command, table_index, table_value,
                   red_in, green_in, blue_in, output ready);
endinterface

interface ptls_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] packed_pixel;

   modport source (output valid, packed_pixel, input ready);
   modport sink   (input valid, packed_pixel, output ready);
endinterface

interface ptls_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] saturation_scale;

   modport source (output valid, saturation_scale, input ready);
   modport sink   (input valid, saturation_scale, output ready);
endinterface

`default_nettype wire

>>> hdl/ptls_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ptls_front
   import ptls_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ptls_req_if.sink    req,
   input  wire logic   queue_full,
   output logic        push,
   output op_type      push_op
);

   logic   front_valid_ff;
   logic   front_valid_in;
   op_type front_op_ff;
   op_type front_op_in;
   logic   accept;

   assign req.ready = !front_valid_ff || !queue_full;
   assign accept    = req.valid && req.ready;
   assign push      = front_valid_ff && !queue_full;
   assign push_op   = front_op_ff;

   // classify: keep only the fields the item's kind needs
   always_comb begin
      front_op_in = front_op_ff;
      if (accept) begin
         if (req.command) begin
            front_op_in.kind   = OP_PIXEL;
            front_op_in.idx[0] = req.red_in;
            front_op_in.idx[1] = req.green_in;
            front_op_in.idx[2] = req.blue_in;
         end else begin
            front_op_in.kind   = OP_TABLE;
            front_op_in.idx[0] = req.table_index;
            front_op_in.idx[1] = req.table_value;
            front_op_in.idx[2] = 8'd0;
         end
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_op_ff <= front_op_in;
   end

endmodule

`default_nettype wire

>>> hdl/ptls_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ptls_queue
   import ptls_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire op_type   push_op,
   input  wire logic     pop,
   output op_type        head,
   output queue_stat_type stat
);

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;
   logic [QUEUE_AW:0]   count_in;

   assign stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ptls_tone_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ptls_tone_mem
   import ptls_pkg::*;
(
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [TABLE_AW-1:0]             wr_addr,
   input  wire logic [7:0]                      wr_data,
   input  wire logic                            rd_en,
   input  wire logic [NUM_CHAN-1:0][TABLE_AW-1:0] rd_addr,
   output logic [NUM_CHAN-1:0][7:0]             rd_data
);

   // one copy per color channel, all written together
   for (genvar lane = 0; lane < NUM_CHAN; lane++) begin : g_lane
      logic [7:0] mem [TABLE_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_data[lane] <= mem[rd_addr[lane]];
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/ptls_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ptls_back
   import ptls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire op_type      head,
   input  wire logic        queue_empty,
   input  wire logic [9:0]  saturation_scale,
   output logic             pop,
   ptls_rsp_if.source       rsp,
   output back_stat_type    stat
);

   logic advance;

   logic [NUM_CHAN-1:0][7:0] mapped;
   logic                     mem_wr_en;
   logic                     mem_rd_en;

   logic                     s1_valid_ff;
   logic                     s2_valid_ff;
   logic                     s3_valid_ff;
   logic                     rsp_valid_ff;

   logic [15:0]              luma_sum;
   logic [7:0]               luma_s2_ff;
   logic [NUM_CHAN-1:0][7:0] chan_s2_ff;

   logic [7:0]               luma_s3_ff;
   logic [NUM_CHAN-1:0][19:0] prod_in;
   logic [NUM_CHAN-1:0][19:0] prod_s3_ff;

   logic [NUM_CHAN-1:0][7:0] result;
   logic [23:0]              packed_ff;

   // whole pipe moves unless the output register is full and stalled
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign pop       = advance && !queue_empty;
   assign mem_wr_en = pop && (head.kind == OP_TABLE);
   assign mem_rd_en = pop && (head.kind == OP_PIXEL);

   ptls_tone_mem u_tone_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (head.idx[0]),
      .wr_data (head.idx[1]),
      .rd_en   (mem_rd_en),
      .rd_addr (head.idx),
      .rd_data (mapped)
   );

   // luma = (77r + 150g + 29b) >> 8, max 65280 fits 16 bits
   assign luma_sum = 16'(LUMA_KR) * 16'(mapped[0])
                   + 16'(LUMA_KG) * 16'(mapped[1])
                   + 16'(LUMA_KB) * 16'(mapped[2]);

   // (c - luma) * scale: 9b signed x 10b unsigned, fits 20b signed
   always_comb begin
      logic [8:0]  diff;
      logic [19:0] diff_ext;
      logic [19:0] scale_ext;
      for (int i = 0; i < NUM_CHAN; i++) begin
         diff       = {1'b0, chan_s2_ff[i]} - {1'b0, luma_s2_ff};
         diff_ext   = {{11{diff[8]}}, diff};
         scale_ext  = {10'd0, saturation_scale};
         prod_in[i] = 20'($signed(diff_ext) * $signed(scale_ext));
      end
   end

   // floor shift by 8, add luma back, clamp to 0..255
   always_comb begin
      logic [12:0] val;
      for (int i = 0; i < NUM_CHAN; i++) begin
         val = {5'd0, luma_s3_ff} + {{1{prod_s3_ff[i][19]}}, prod_s3_ff[i][19:8]};
         if (val[12]) begin
            result[i] = 8'd0;
         end else if (val[11:8] != 4'd0) begin
            result[i] = CHAN_MAX;
         end else begin
            result[i] = val[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= mem_rd_en;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         luma_s2_ff <= luma_sum[15:8];
         chan_s2_ff <= mapped;
         luma_s3_ff <= luma_s2_ff;
         prod_s3_ff <= prod_in;
         packed_ff  <= {result[0], result[1], result[2]};
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.packed_pixel = packed_ff;

   assign stat.pop      = pop;
   assign stat.s3_valid = s3_valid_ff;

endmodule

`default_nettype wire

>>> hdl/pixel_tone_lut_saturation.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel tone mapping with luma-based saturation. A req transaction with
// command 0 writes table_value into tone table entry table_index and yields
// no rsp; one with command 1 maps red_in, green_in, blue_in through the
// table, takes luma = (77r + 150g + 29b) >> 8, scales each channel's offset
// from luma by saturation_scale (2.8 fixed point, floor), adds it back,
// clamps to 0..255 and returns one rsp transaction with packed_pixel =
// r<<16 | g<<8 | b. Results come out in request order. Throughput is one
// transaction per clock when rsp is not stalled; a pixel's result passes
// in turn through the front register, the four-entry queue and the
// four-stage back pipeline (table read, luma, gain multiply,
// shift/clamp). The tone table is held in three copies, one
// read port per color. Entries must be written before a pixel reads them;
// a write is seen by any pixel requested after it. saturation_scale resets
// to 332 and may only be written while no transaction is in flight.

module pixel_tone_lut_saturation
   import ptls_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ptls_req_if.sink    req,
   ptls_rsp_if.source  rsp,
   ptls_csr_if.sink    csr
);

   // --- configuration -----------------------------------------------------
   logic [9:0] scale_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SAT_RESET;
      end else if (csr.valid) begin
         scale_ff <= csr.saturation_scale;
      end
   end

   // --- front: accept and classify ----------------------------------------
   logic           push;
   op_type         push_op;
   op_type         head;
   logic           back_pop;
   queue_stat_type q_stat;
   back_stat_type  back_stat;

   ptls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (q_stat.full),
      .push       (push),
      .push_op    (push_op)
   );

   // --- queue decouples front from back -----------------------------------
   ptls_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (back_pop),
      .head    (head),
      .stat    (q_stat)
   );

   // --- back: table access, luma, gain, clamp, output register ------------
   ptls_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .queue_empty      (q_stat.empty),
      .saturation_scale (scale_ff),
      .pop              (back_pop),
      .rsp              (rsp),
      .stat             (back_stat)
   );

`ifndef SYNTH
   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // a stalled result freezes the back end
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !back_stat.pop)
      else $error("queue popped during output stall");

   // a result only appears from the last pipeline stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(back_stat.s3_valid))
      else $error("result without a pixel in the pipeline");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ptls_pkg::*;

   // Run limits. The timeout sits far above the slowest correct run:
   // about 1400 transactions, 8% gaps on each side, plus the drain
   // before each gain change.
   localparam int CYCLE_LIMIT  = 100000;
   localparam int SETTLE_TICKS = 12;      // margin past the pixel pipeline
   localparam int UNIT_GAIN    = 256;     // 2.8 fixed point 1.0
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 225;
   localparam int ROWS         = 21;

   // One row of the directed plan. typed = 1 means the expected word
   // is written into the row; otherwise the tone mapper predicts it.
   typedef struct {
      logic [9:0]  gain;
      op_kind_type op;
      logic [7:0]  t_idx;
      logic [7:0]  t_val;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      bit          typed;
      logic [23:0] want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;

   ptls_req_if req_if ();
   ptls_rsp_if rsp_if ();
   ptls_csr_if csr_if ();

   pixel_tone_lut_saturation dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Directed plan: extremes of every field, both ops, unit gain,
   // gain 0 / 1 / 1023, clamping at both ends, and an entry overwrite.
   // Table writes carry junk pixel fields; pixels carry junk table fields.
   plan_row_type plan [0:ROWS-1] = '{
      '{10'd332,  OP_TABLE, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, 24'h0},
      '{10'd332,  OP_TABLE, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
      '{10'd332,  OP_TABLE, 8'h80, 8'h80, 8'h5a, 8'ha5, 8'h3c, 1'b0, 24'h0},
      '{10'd332,  OP_TABLE, 8'h01, 8'hc8, 8'h00, 8'hff, 8'h00, 1'b0, 24'h0},
      '{10'd332,  OP_TABLE, 8'hfe, 8'h11, 8'hff, 8'h00, 8'hff, 1'b0, 24'h0},
      // reset gain: black and white stay put, pure red clamps high and low
      '{10'd332,  OP_PIXEL, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
      '{10'd332,  OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff},
      '{10'd332,  OP_PIXEL, 8'h5a, 8'ha5, 8'hff, 8'h00, 8'h00, 1'b1, 24'hff0000},
      '{10'd332,  OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 24'h0},
      '{10'd332,  OP_PIXEL, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 24'h0},
      // unit gain: mapped channels pass straight through
      '{10'd256,  OP_PIXEL, 8'h00, 8'h00, 8'h01, 8'hfe, 8'h80, 1'b1, 24'hc81180},
      '{10'd256,  OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'h00, 8'h80, 1'b1, 24'hff0080},
      // zero gain: every channel collapses to luma
      '{10'd0,    OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 1'b1, 24'h4c4c4c},
      '{10'd0,    OP_PIXEL, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 1'b1, 24'h808080},
      '{10'd1023, OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 24'h0},
      '{10'd1023, OP_PIXEL, 8'hff, 8'hff, 8'h01, 8'hfe, 8'h80, 1'b0, 24'h0},
      // overwrite an entry, then read it back
      '{10'd1023, OP_TABLE, 8'h80, 8'h05, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
      '{10'd1023, OP_PIXEL, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 1'b1, 24'h050505},
      '{10'd1023, OP_PIXEL, 8'h00, 8'h00, 8'h80, 8'h01, 8'hfe, 1'b0, 24'h0},
      '{10'd1,    OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0, 24'h0},
      '{10'd1,    OP_PIXEL, 8'hff, 8'hff, 8'h01, 8'hfe, 8'hff, 1'b0, 24'h0}
   };

   // Tone mapper state, updated at each accepted transaction.
   logic [7:0]  tone_mirror [0:TABLE_DEPTH-1];
   logic [9:0]  model_gain = SAT_RESET;
   logic [23:0] pending_pixels [$];

   // Sideband that travels with each req transaction: a typed expectation
   // from the directed plan, sampled together with the payload.
   bit          req_typed = 1'b0;
   logic [23:0] req_want  = 24'h0;

   // Generator-side bookkeeping: which entries hold data already.
   bit          entry_written [0:TABLE_DEPTH-1];
   int          written_list [$];
   logic [9:0]  drive_gain = SAT_RESET;

   bit          calm = 1'b0;          // no idling on either side
   int          mismatch_count = 0;
   int          cycle_count = 0;
   logic [23:0] got_pixel;
   logic [23:0] want_pixel;

   // -----------------------------------------------------------------
   // Clock, reset, timeout
   // -----------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, pending_pixels.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -----------------------------------------------------------------
   // Tone mapper: table lookup, luma, gain on the offset, clamp, pack
   // -----------------------------------------------------------------
   function automatic logic [7:0] saturate_chan(input int c, input int luma,
                                                input int gain);
      int v;
      v = luma + (((c - luma) * gain) >>> 8);   // floor toward minus infinity
      if (v < 0) return 8'd0;
      if (v > int'(CHAN_MAX)) return CHAN_MAX;
      return v[7:0];
   endfunction

   function automatic logic [23:0] tone_map_pixel(input logic [7:0] ri,
                                                  input logic [7:0] gi,
                                                  input logic [7:0] bi);
      int r, g, b, luma, gain;
      r    = int'(tone_mirror[ri]);
      g    = int'(tone_mirror[gi]);
      b    = int'(tone_mirror[bi]);
      gain = int'(model_gain);
      // unit gain is an identity under the floor shift, no special path needed
      luma = (int'(LUMA_KR) * r + int'(LUMA_KG) * g + int'(LUMA_KB) * b) >>> 8;
      return {saturate_chan(r, luma, gain), saturate_chan(g, luma, gain),
              saturate_chan(b, luma, gain)};
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // -----------------------------------------------------------------
   // Monitor: all three channels sampled at the same edge, pre-update
   // values. Prediction is queued before the rsp check so a same-edge
   // pair would still line up.
   // -----------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            model_gain = csr_if.saturation_scale;

         if (req_if.valid && req_if.ready) begin
            if (req_if.command == OP_TABLE) begin
               tone_mirror[req_if.table_index] = req_if.table_value;
            end else if (req_typed) begin
               pending_pixels.push_back(req_want);
            end else begin
               pending_pixels.push_back(tone_map_pixel(req_if.red_in,
                                                       req_if.green_in,
                                                       req_if.blue_in));
            end
         end

         if (rsp_if.valid && rsp_if.ready) begin
            got_pixel = rsp_if.packed_pixel;
            if (pending_pixels.size() == 0) begin
               flag_mismatch($sformatf("rsp %06h with no pixel pending", got_pixel));
            end else begin
               want_pixel = pending_pixels.pop_front();
               if (got_pixel !== want_pixel)
                  flag_mismatch($sformatf("packed_pixel %06h, want %06h",
                                          got_pixel, want_pixel));
            end
         end
      end
   end

   // Result side backpressure: stall about 8% of the time unless calm.
   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99) >= 8);
   end

   // -----------------------------------------------------------------
   // Drivers
   // -----------------------------------------------------------------

   // One req transaction. Returns on the edge that accepts it with valid
   // still high, so a back-to-back follower keeps valid up without a dip.
   task automatic send_item(input op_kind_type op, input logic [7:0] t_idx,
                            input logic [7:0] t_val, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b,
                            input bit typed, input logic [23:0] want);
      while (!calm && $urandom_range(99) < 8) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= op;
      req_if.table_index <= t_idx;
      req_if.table_value <= t_val;
      req_if.red_in      <= r;
      req_if.green_in    <= g;
      req_if.blue_in     <= b;
      req_typed          <= typed;
      req_want           <= want;
      if (op == OP_TABLE && !entry_written[t_idx]) begin
         entry_written[t_idx] = 1'b1;
         written_list.push_back(int'(t_idx));
      end
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Let every pixel come back, then a few more cycles for table writes
   // still in the pipe, since those never show up on rsp.
   task automatic drain_block();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Gain change only with the block idle.
   task automatic write_gain(input logic [9:0] gain);
      req_if.valid <= 1'b0;
      drain_block();
      csr_if.valid            <= 1'b1;
      csr_if.saturation_scale <= gain;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      drive_gain = gain;
   endtask

   // Random index that is known to hold data.
   function automatic logic [7:0] pick_entry();
      int i;
      i = $urandom_range(TABLE_DEPTH - 1);
      if (!entry_written[i[7:0]])
         i = written_list[$urandom_range(written_list.size() - 1)];
      return i[7:0];
   endfunction

   // -----------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------
   initial begin
      int          p, k;
      logic [9:0]  phase_gain;
      logic [7:0]  tv;

      req_if.valid            <= 1'b0;
      req_if.command          <= OP_TABLE;
      req_if.table_index      <= 8'h00;
      req_if.table_value      <= 8'h00;
      req_if.red_in           <= 8'h00;
      req_if.green_in         <= 8'h00;
      req_if.blue_in          <= 8'h00;
      csr_if.valid            <= 1'b0;
      csr_if.saturation_scale <= SAT_RESET;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         entry_written[k] = 1'b0;
         tone_mirror[k]   = 8'h00;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan
      for (k = 0; k < ROWS; k++) begin
         if (plan[k].gain != drive_gain)
            write_gain(plan[k].gain);
         send_item(plan[k].op, plan[k].t_idx, plan[k].t_val, plan[k].r,
                   plan[k].g, plan[k].b, plan[k].typed, plan[k].want);
      end

      // random phases: arbitrary gain, unit gain, a calm zero-gain phase,
      // full-scale gain, low gain, high gain
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: phase_gain = 10'($urandom_range(1023));
            1: phase_gain = 10'(UNIT_GAIN);
            2: phase_gain = 10'd0;
            3: phase_gain = 10'd1023;
            4: phase_gain = 10'($urandom_range(255));
            default: phase_gain = 10'($urandom_range(1023, 512));
         endcase
         if (phase_gain != drive_gain)
            write_gain(phase_gain);
         calm <= (p == 2);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 30) begin
               // lean on the rails now and then to push clamping
               if ($urandom_range(99) < 15)
                  tv = $urandom_range(1) ? CHAN_MAX : 8'h00;
               else
                  tv = 8'($urandom_range(255));
               send_item(OP_TABLE, 8'($urandom_range(255)), tv,
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 1'b0, 24'h0);
            end else begin
               send_item(OP_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         pick_entry(), pick_entry(), pick_entry(), 1'b0, 24'h0);
            end
         end
      end

      req_if.valid <= 1'b0;
      calm <= 1'b0;
      drain_block();

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
